// File: hdl/spt_pkg.sv
// shared constants, codes and types of the sorted priority table
// no dependencies; compile first
package spt_pkg;

  localparam int CAPACITY = 32;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam int TYPE_W   = 3;
  localparam int TICKET_W = 16;
  localparam int SEV_W    = 3;
  localparam int AGE_W    = 8;
  localparam int STATUS_W = 3;

  localparam logic [SEV_W-1:0] SEV_MIN = 3'd1;
  localparam logic [SEV_W-1:0] SEV_MAX = 3'd4;

  // request kinds
  localparam logic [TYPE_W-1:0] REQ_INSERT = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_FIND   = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_UPDATE = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_DELETE = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_LIST   = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_BADSEV   = 3'd5;

  typedef struct packed {
    logic [TICKET_W-1:0] ticket;
    logic [SEV_W-1:0]    severity;
    logic [AGE_W-1:0]    age;
  } entry_t;

  typedef struct packed {
    logic eq;     // same ticket
    logic ahead;  // stored entry sorts ahead of the key
  } cmp_res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MOVE,
    S_PLACE,
    S_RESP,
    S_LIST_RD,
    S_LIST_LD
  } state_t;

endpackage

// File: hdl/spt_if.sv
// request and result channel interfaces of the sorted priority table
// depends on spt_pkg
interface spt_in_if import spt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [TYPE_W-1:0]   req_type;
  logic [TICKET_W-1:0] ticket;
  logic [SEV_W-1:0]    severity;
  logic [AGE_W-1:0]    age;

  modport source (output valid, req_type, ticket, severity, age, input ready);
  modport sink   (input valid, req_type, ticket, severity, age, output ready);
endinterface

interface spt_out_if import spt_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TICKET_W-1:0] out_ticket;
  logic [SEV_W-1:0]    out_severity;
  logic [AGE_W-1:0]    out_age;
  logic                last;

  modport source (output valid, status, out_ticket, out_severity, out_age, last,
                  input ready);
  modport sink   (input valid, status, out_ticket, out_severity, out_age, last,
                  output ready);
endinterface

// File: hdl/spt_mem.sv
// slot memory: one write port, one read port with registered read data
// depends on spt_pkg
module spt_mem import spt_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem_r [CAPACITY];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read data holds while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hdl/spt_cmp.sv
// shared compare unit: ticket match and sort order of a stored entry against the key
// depends on spt_pkg
module spt_cmp import spt_pkg::*; (
  input  entry_t   ent,
  input  entry_t   key,
  output cmp_res_t res
);

  always_comb begin
    res.eq = (ent.ticket == key.ticket);
    if (ent.severity != key.severity) begin
      res.ahead = (ent.severity < key.severity);
    end else begin
      res.ahead = (ent.ticket < key.ticket);
    end
  end

endmodule

// File: hdl/sorted_priority_table.sv
// sorted priority table top level: sequencer, occupancy and result register
// depends on spt_pkg, spt_if, spt_mem and spt_cmp
//
//   channel  dir  handshake      payload
//   in_ch    in   valid/ready    req_type, ticket, severity, age
//   out_ch   out  valid/ready    status, out_ticket, out_severity, out_age, last
//
// insert, find, update and delete scan the table once (S_SCAN) and decide in S_DECIDE;
// a successful insert, update or delete then shifts the entries between old and new
// place (S_MOVE), insert and update write the new entry (S_PLACE), and S_RESP loads
// the result. a list request reads and sends one entry at a time (S_LIST_RD, then
// S_LIST_LD) through the single read port of the slot memory. one request is in work
// at a time.
// reset clears occupancy, state and flags only; slots are never read before written.
// a stalled result holds the sequencer in its result state until taken.
module sorted_priority_table import spt_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  spt_in_if.sink  in_ch,
  spt_out_if.source out_ch
);

  state_t state_r, state_nxt;

  logic [TYPE_W-1:0]   req_kind_r, req_kind_nxt;
  entry_t              key_r, key_nxt;
  logic [CNT_W-1:0]    occ_r, occ_nxt;
  logic [CNT_W-1:0]    rd_i_r, rd_i_nxt;
  logic                cmp_vld_r, cmp_vld_nxt;
  logic [CNT_W-1:0]    cmp_idx_r, cmp_idx_nxt;
  logic                found_r, found_nxt;
  logic [CNT_W-1:0]    m_r, m_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  entry_t              hit_r, hit_nxt;
  logic [IDX_W-1:0]    mv_src_r, mv_src_nxt;
  logic [CNT_W-1:0]    mv_left_r, mv_left_nxt;
  logic                mv_up_r, mv_up_nxt;
  logic                wr_pend_r, wr_pend_nxt;
  logic [IDX_W-1:0]    wr_addr_r, wr_addr_nxt;
  logic [STATUS_W-1:0] resp_st_r, resp_st_nxt;
  entry_t              resp_ent_r, resp_ent_nxt;

  logic                out_vld_r, out_vld_nxt;
  logic [STATUS_W-1:0] out_st_r, out_st_nxt;
  entry_t              out_ent_r, out_ent_nxt;
  logic                out_last_r, out_last_nxt;

  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  cmp_res_t         cmp_res;

  logic in_acc;
  logic out_free;
  logic sev_ok;

  spt_mem u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  spt_cmp u_cmp (
    .ent (mem_rd_data),
    .key (key_r),
    .res (cmp_res)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_acc      = in_ch.valid && (state_r == S_IDLE);
  assign out_free    = !out_vld_r || out_ch.ready;
  assign sev_ok      = key_r.severity inside {[SEV_MIN:SEV_MAX]};

  assign out_ch.valid        = out_vld_r;
  assign out_ch.status       = out_st_r;
  assign out_ch.out_ticket   = out_ent_r.ticket;
  assign out_ch.out_severity = out_ent_r.severity;
  assign out_ch.out_age      = out_ent_r.age;
  assign out_ch.last         = out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      occ_r      <= '0;
      cmp_vld_r  <= 1'b0;
      wr_pend_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      occ_r      <= occ_nxt;
      cmp_vld_r  <= cmp_vld_nxt;
      wr_pend_r  <= wr_pend_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_kind_r <= req_kind_nxt;
    key_r      <= key_nxt;
    rd_i_r     <= rd_i_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    found_r    <= found_nxt;
    m_r        <= m_nxt;
    cnt_r      <= cnt_nxt;
    hit_r      <= hit_nxt;
    mv_src_r   <= mv_src_nxt;
    mv_left_r  <= mv_left_nxt;
    mv_up_r    <= mv_up_nxt;
    wr_addr_r  <= wr_addr_nxt;
    resp_st_r  <= resp_st_nxt;
    resp_ent_r <= resp_ent_nxt;
    out_st_r   <= out_st_nxt;
    out_ent_r  <= out_ent_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    req_kind_nxt = req_kind_r;
    key_nxt      = key_r;
    occ_nxt      = occ_r;
    rd_i_nxt     = rd_i_r;
    cmp_vld_nxt  = 1'b0;
    cmp_idx_nxt  = cmp_idx_r;
    found_nxt    = found_r;
    m_nxt        = m_r;
    cnt_nxt      = cnt_r;
    hit_nxt      = hit_r;
    mv_src_nxt   = mv_src_r;
    mv_left_nxt  = mv_left_r;
    mv_up_nxt    = mv_up_r;
    wr_pend_nxt  = 1'b0;
    wr_addr_nxt  = wr_addr_r;
    resp_st_nxt  = resp_st_r;
    resp_ent_nxt = resp_ent_r;
    out_vld_nxt  = out_vld_r && !out_ch.ready;
    out_st_nxt   = out_st_r;
    out_ent_nxt  = out_ent_r;
    out_last_nxt = out_last_r;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = wr_addr_r;
    mem_wr_data  = mem_rd_data;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = rd_i_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          req_kind_nxt = in_ch.req_type;
          key_nxt      = '{ticket: in_ch.ticket, severity: in_ch.severity, age: in_ch.age};
          rd_i_nxt     = '0;
          found_nxt    = 1'b0;
          cnt_nxt      = '0;
          case (in_ch.req_type)
            REQ_INSERT, REQ_FIND, REQ_UPDATE, REQ_DELETE: begin
              state_nxt = S_SCAN;
            end
            REQ_LIST: begin
              if (occ_r == '0) begin
                resp_st_nxt  = ST_EMPTY;
                resp_ent_nxt = '0;
                state_nxt    = S_RESP;
              end else begin
                state_nxt = S_LIST_RD;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (rd_i_r != occ_r) begin
          mem_rd_en   = 1'b1;
          rd_i_nxt    = rd_i_r + 1'b1;
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_i_r;
        end else if (!cmp_vld_r) begin
          state_nxt = S_DECIDE;
        end
        // cnt ends as the key's place in the table without the matching entry
        if (cmp_vld_r) begin
          if (cmp_res.eq) begin
            found_nxt = 1'b1;
            m_nxt     = cmp_idx_r;
            hit_nxt   = mem_rd_data;
          end else if (cmp_res.ahead) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
      end

      S_DECIDE: begin
        resp_ent_nxt = '0;
        state_nxt    = S_RESP;
        case (req_kind_r)
          REQ_INSERT: begin
            if (found_r) begin
              resp_st_nxt = ST_DUP;
            end else if (!sev_ok) begin
              resp_st_nxt = ST_BADSEV;
            end else if (occ_r == CNT_W'(CAPACITY)) begin
              resp_st_nxt = ST_FULL;
            end else begin
              resp_st_nxt  = ST_OK;
              resp_ent_nxt = key_r;
              mv_up_nxt    = 1'b1;
              mv_src_nxt   = IDX_W'(occ_r - 1'b1);
              mv_left_nxt  = occ_r - cnt_r;
              state_nxt    = S_MOVE;
            end
          end
          REQ_FIND: begin
            if (found_r) begin
              resp_st_nxt  = ST_OK;
              resp_ent_nxt = hit_r;
            end else begin
              resp_st_nxt = ST_NOTFOUND;
            end
          end
          REQ_UPDATE: begin
            if (!found_r) begin
              resp_st_nxt = ST_NOTFOUND;
            end else if (!sev_ok) begin
              resp_st_nxt = ST_BADSEV;
            end else begin
              resp_st_nxt  = ST_OK;
              resp_ent_nxt = key_r;
              state_nxt    = S_MOVE;
              // moving toward the front shifts the entries in between up, else down
              if (cnt_r <= m_r) begin
                mv_up_nxt   = 1'b1;
                mv_src_nxt  = IDX_W'(m_r - 1'b1);
                mv_left_nxt = m_r - cnt_r;
              end else begin
                mv_up_nxt   = 1'b0;
                mv_src_nxt  = IDX_W'(m_r + 1'b1);
                mv_left_nxt = cnt_r - m_r;
              end
            end
          end
          REQ_DELETE: begin
            if (!found_r) begin
              resp_st_nxt = ST_NOTFOUND;
            end else begin
              resp_st_nxt  = ST_OK;
              resp_ent_nxt = hit_r;
              mv_up_nxt    = 1'b0;
              mv_src_nxt   = IDX_W'(m_r + 1'b1);
              mv_left_nxt  = occ_r - m_r - 1'b1;
              state_nxt    = S_MOVE;
            end
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_MOVE: begin
        if (wr_pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = wr_addr_r;
          mem_wr_data = mem_rd_data;
        end
        if (mv_left_r != '0) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = mv_src_r;
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = mv_up_r ? mv_src_r + 1'b1 : mv_src_r - 1'b1;
          mv_src_nxt  = mv_up_r ? mv_src_r - 1'b1 : mv_src_r + 1'b1;
          mv_left_nxt = mv_left_r - 1'b1;
        end else if (!wr_pend_r) begin
          if (req_kind_r == REQ_DELETE) begin
            occ_nxt   = occ_r - 1'b1;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_PLACE;
          end
        end
      end

      S_PLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = cnt_r[IDX_W-1:0];
        mem_wr_data = key_r;
        if (req_kind_r == REQ_INSERT) begin
          occ_nxt = occ_r + 1'b1;
        end
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_st_nxt   = resp_st_r;
          out_ent_nxt  = resp_ent_r;
          out_last_nxt = 1'b1;
          state_nxt    = S_IDLE;
        end
      end

      S_LIST_RD: begin
        mem_rd_en = 1'b1;
        state_nxt = S_LIST_LD;
      end

      S_LIST_LD: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_st_nxt   = ST_OK;
          out_ent_nxt  = mem_rd_data;
          out_last_nxt = ((rd_i_r + 1'b1) == occ_r);
          if ((rd_i_r + 1'b1) == occ_r) begin
            state_nxt = S_IDLE;
          end else begin
            rd_i_nxt  = rd_i_r + 1'b1;
            state_nxt = S_LIST_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

`ifndef SYNTH
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (occ_r != $past(occ_r))) |->
      ((occ_r == $past(occ_r) + 1'b1) || (occ_r + 1'b1 == $past(occ_r))))
    else $error("occupancy moved by more than one");

  a_scan_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DECIDE) |-> (rd_i_r == occ_r))
    else $error("scan ended before covering all entries");

  a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("slot read and write hit the same address");

  a_hit_match: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DECIDE) && found_r) |-> (hit_r.ticket == key_r.ticket))
    else $error("captured entry does not match the key");
`endif

endmodule
